### sv/sopa_pkg.sv
// Package for the suffix-prefix overlap aligner.
// Holds sizes, command codes and the types shared by the front, back and top level.
package sopa_pkg;

  localparam int MaxLen = 256;

  localparam int LEN_W = $clog2(MaxLen + 1);
  localparam int AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int SCORE_RAW_W = $clog2(15 * MaxLen + 32) + 2;
  localparam int SCORE_W = (SCORE_RAW_W > 14) ? SCORE_RAW_W : 14;

  localparam int SYM_W = 8;
  localparam int CFG_W = 4;
  localparam int CMD_W = 2;
  localparam int CIDX_W = 2;
  localparam int RES_W = 12;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam int QCNT_W = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND_FIRST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALIGN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam logic [CIDX_W-1:0] REG_MATCH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INDEL = 2'd2;

  localparam logic [CFG_W-1:0] MATCH_RST = 4'd1;
  localparam logic [CFG_W-1:0] MISMATCH_RST = 4'd1;
  localparam logic [CFG_W-1:0] INDEL_RST = 4'd2;

  localparam logic [RES_W-1:0] SCORE_CEIL = 12'd4095;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_SECOND,
    OP_ALIGN
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] symbol;
  } q_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] hit_gain;
    logic [CFG_W-1:0] miss_cost;
    logic [CFG_W-1:0] gap_cost;
  } cfg_t;

endpackage

### sv/sopa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sopa_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/sopa_front.sv
// Front end: accepts input items, classifies commands and queues them for the back end.
// Depends on sopa_pkg.
module sopa_front import sopa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [SYM_W-1:0] symbol_i,
  output logic             q_valid_o,
  output q_item_t          q_item_o,
  input  logic             q_pop_i
);

  q_item_t           fifo_q [QDEPTH];
  logic [QAW-1:0]    wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  op_e               op;
  logic              known;

  always_comb begin
    known = 1'b1;
    op = OP_FIRST;
    case (command_i)
      CMD_APPEND_FIRST:  op = OP_FIRST;
      CMD_APPEND_SECOND: op = OP_SECOND;
      CMD_ALIGN:         op = OP_ALIGN;
      default:           known = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == QCNT_W'(QDEPTH));
  // An unused command is accepted and dropped.
  assign push = in_valid_i && !in_stall_o && known;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{op: op, symbol: symbol_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + QAW'(1);
      if (q_pop_i) rptr_q <= rptr_q + QAW'(1);
      cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(q_pop_i);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != '0) else $error("pop from empty queue");
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("queue count overflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("queue count did not advance");

endmodule

### sv/sopa_back.sv
// Back end: stores read symbols and runs the column-by-column overlap alignment.
// Depends on sopa_pkg and sopa_ram.
module sopa_back import sopa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_valid_i,
  input  q_item_t          q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RES_W-1:0] best_score_o,
  output logic             too_long_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DP,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [LEN_W-1:0]          len1_q, len2_q;
  logic                      ovf_q;
  logic [AW-1:0]             col_q, iss_q, prow_q;
  logic                      iss_en_q, pv_q;
  logic signed [SCORE_W-1:0] diag_q, up_q, z_q, best_q;
  logic                      out_valid_q, out_tl_q;
  logic [RES_W-1:0]          out_score_q;

  logic [SYM_W-1:0]          first_rd, second_rd;
  logic [SCORE_W-1:0]        col_rd;
  logic                      we1, we2;
  logic signed [SCORE_W-1:0] ms_s, mm_s, gp_s, left, dterm, hterm, vterm, new_score;
  logic                      res_load, last_row, last_col;
  logic [LEN_W-1:0]          lim;

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign we1 = q_pop_o && (q_item_i.op == OP_FIRST) && (len1_q < LEN_W'(MaxLen));
  assign we2 = q_pop_o && (q_item_i.op == OP_SECOND) && (len2_q < LEN_W'(MaxLen));

  sopa_ram #(.Width(SYM_W), .Depth(MaxLen)) u_first (
    .clk_i, .we_i(we1), .waddr_i(len1_q[AW-1:0]), .wdata_i(q_item_i.symbol),
    .raddr_i(col_q), .rdata_o(first_rd)
  );

  sopa_ram #(.Width(SYM_W), .Depth(MaxLen)) u_second (
    .clk_i, .we_i(we2), .waddr_i(len2_q[AW-1:0]), .wdata_i(q_item_i.symbol),
    .raddr_i(iss_q), .rdata_o(second_rd)
  );

  sopa_ram #(.Width(SCORE_W), .Depth(MaxLen)) u_column (
    .clk_i, .we_i(pv_q), .waddr_i(prow_q), .wdata_i(new_score),
    .raddr_i(iss_q), .rdata_o(col_rd)
  );

  always_comb begin
    ms_s = signed'(SCORE_W'(cfg_i.hit_gain));
    mm_s = signed'(SCORE_W'(cfg_i.miss_cost));
    gp_s = signed'(SCORE_W'(cfg_i.gap_cost));
    // The first column reads the gap-only column zero instead of memory.
    left = (col_q == '0) ? z_q : signed'(col_rd);
    dterm = (first_rd == second_rd) ? diag_q + ms_s : diag_q - mm_s;
    hterm = up_q - gp_s;
    vterm = left - gp_s;
    new_score = dterm;
    if (hterm > new_score) new_score = hterm;
    if (vterm > new_score) new_score = vterm;
    last_row = (LEN_W'(prow_q) == len2_q - LEN_W'(1));
    last_col = (LEN_W'(col_q) == len1_q - LEN_W'(1));
    lim = (len1_q < len2_q) ? len1_q : len2_q;
    res_load = (state_q == ST_DONE) && !out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len1_q <= '0;
      len2_q <= '0;
      ovf_q <= 1'b0;
      col_q <= '0;
      iss_q <= '0;
      prow_q <= '0;
      iss_en_q <= 1'b0;
      pv_q <= 1'b0;
      diag_q <= '0;
      up_q <= '0;
      z_q <= '0;
      best_q <= '0;
      out_valid_q <= 1'b0;
      out_tl_q <= 1'b0;
      out_score_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            case (q_item_i.op)
              OP_FIRST: begin
                if (we1) len1_q <= len1_q + LEN_W'(1);
                else ovf_q <= 1'b1;
              end
              OP_SECOND: begin
                if (we2) len2_q <= len2_q + LEN_W'(1);
                else ovf_q <= 1'b1;
              end
              OP_ALIGN: begin
                best_q <= '0;
                if (len1_q == '0 || len2_q == '0) begin
                  state_q <= ST_DONE;
                end else begin
                  state_q <= ST_DP;
                  col_q <= '0;
                  iss_q <= '0;
                  iss_en_q <= 1'b1;
                  pv_q <= 1'b0;
                  diag_q <= '0;
                  up_q <= '0;
                  z_q <= -gp_s;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_DP: begin
          prow_q <= iss_q;
          if (iss_en_q) begin
            if (LEN_W'(iss_q) == len2_q - LEN_W'(1)) iss_en_q <= 1'b0;
            else iss_q <= iss_q + AW'(1);
          end
          if (pv_q) begin
            z_q <= z_q - gp_s;
            if (last_col && LEN_W'(prow_q) < lim && new_score > best_q) begin
              best_q <= new_score;
            end
          end
          if (pv_q && last_row) begin
            // The next column starts reading only after this write lands.
            pv_q <= 1'b0;
            diag_q <= '0;
            up_q <= '0;
            if (last_col) begin
              state_q <= ST_DONE;
            end else begin
              col_q <= col_q + AW'(1);
              iss_q <= '0;
              iss_en_q <= 1'b1;
            end
          end else begin
            pv_q <= iss_en_q;
            if (pv_q) begin
              up_q <= new_score;
              diag_q <= left;
            end
          end
        end
        ST_DONE: begin
          if (res_load) begin
            out_valid_q <= 1'b1;
            out_tl_q <= ovf_q;
            out_score_q <= (best_q > signed'(SCORE_W'(SCORE_CEIL))) ? SCORE_CEIL
                                                                   : best_q[RES_W-1:0];
            len1_q <= '0;
            len2_q <= '0;
            ovf_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_score_o = out_score_q;
  assign too_long_o = out_tl_q;

  a_pv_in_dp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> state_q == ST_DP) else $error("column write outside alignment");
  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DP && iss_en_q) |-> LEN_W'(iss_q) < len2_q)
    else $error("row index beyond second read");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_q) else $error("result not presented");
  a_load_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (len1_q == '0 && len2_q == '0 && !ovf_q))
    else $error("reads not cleared after align");

endmodule

### sv/suffix_prefix_overlap_align.sv
// Top level of the suffix-prefix overlap aligner: configuration registers, front and back.
// Depends on sopa_pkg, sopa_front and sopa_back.
//
// An append item waits in the queue and is written to its read memory while the back is
// idle. An align item with both read lengths nonzero runs the column sweep and then loads
// the result register; with an empty read it goes straight to the result. The queue takes
// one append per cycle unless full; the sweep fills one score cell per cycle in a column.
// Reset clears lengths, flags, queue and registers at once; no memory clearing pass.
module suffix_prefix_overlap_align import sopa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [SYM_W-1:0]  symbol_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RES_W-1:0]  best_score_o,
  output logic              too_long_o
);

  cfg_t    cfg_q;
  logic    q_valid, q_pop;
  q_item_t q_item;

  // Scoring registers. A write to an unused index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{hit_gain: MATCH_RST, miss_cost: MISMATCH_RST,
                 gap_cost: INDEL_RST};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MATCH:    cfg_q.hit_gain <= cfg_wdata_i;
        REG_MISMATCH: cfg_q.miss_cost <= cfg_wdata_i;
        REG_INDEL:    cfg_q.gap_cost <= cfg_wdata_i;
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // The front accepts and classifies items into a short queue, so input keeps
  // flowing while the back is busy with an alignment or holds a stalled result.
  sopa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .symbol_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  // The back stores the reads and runs the score sweep; its result sits in an
  // output register so appends after an align can proceed while it waits.
  sopa_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .best_score_o, .too_long_o
  );

endmodule

### test/overlap_checker.sv
// Checker for the suffix-prefix overlap aligner: predicts every align result and compares.
// Depends on sopa_pkg; watches the configuration port and both item channels of the block.
`timescale 1ns / 100ps

module overlap_checker import sopa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [RES_W-1:0]  best_score_i,
  input  logic              too_long_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct {
    logic [RES_W-1:0] best_score;
    logic             too_long;
  } overlap_result_t;

  logic [SYM_W-1:0] first_read [MaxLen];
  logic [SYM_W-1:0] second_read [MaxLen];
  int               first_len;
  int               second_len;
  logic             dropped;
  cfg_t             weights;
  overlap_result_t  awaited_scores [$];

  // Column-wise dynamic program; row zero is free, column zero pays one indel per symbol.
  function automatic logic [RES_W-1:0] score_overlap();
    int col [MaxLen + 1];
    int diag;
    int left;
    int d;
    int best;
    int lim;
    best = 0;
    for (int i = 0; i <= second_len; i++) col[i] = -int'(weights.gap_cost) * i;
    for (int j = 1; j <= first_len; j++) begin
      diag = col[0];
      col[0] = 0;
      for (int i = 1; i <= second_len; i++) begin
        left = col[i];
        if (first_read[j-1] == second_read[i-1]) d = diag + int'(weights.hit_gain);
        else d = diag - int'(weights.miss_cost);
        if (col[i-1] - int'(weights.gap_cost) > d) d = col[i-1] - int'(weights.gap_cost);
        if (left - int'(weights.gap_cost) > d) d = left - int'(weights.gap_cost);
        col[i] = d;
        diag = left;
      end
    end
    lim = (first_len < second_len) ? first_len : second_len;
    for (int i = 0; i <= lim; i++) if (col[i] > best) best = col[i];
    if (best > int'(SCORE_CEIL)) best = int'(SCORE_CEIL);
    return best[RES_W-1:0];
  endfunction

  assign pending_o = awaited_scores.size();

  always @(posedge clk_i or negedge rst_ni) begin
    overlap_result_t got;
    overlap_result_t want;
    int errs;
    if (!rst_ni) begin
      first_len <= 0;
      second_len <= 0;
      dropped <= 1'b0;
      weights <= '{MATCH_RST, MISMATCH_RST, INDEL_RST};
      fail_count_o <= 0;
      awaited_scores.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MATCH: weights.hit_gain <= cfg_wdata_i;
          REG_MISMATCH: weights.miss_cost <= cfg_wdata_i;
          REG_INDEL: weights.gap_cost <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_APPEND_FIRST: begin
            if (first_len < MaxLen) begin
              first_read[first_len] = symbol_i;
              first_len <= first_len + 1;
            end else begin
              dropped <= 1'b1;
            end
          end
          CMD_APPEND_SECOND: begin
            if (second_len < MaxLen) begin
              second_read[second_len] = symbol_i;
              second_len <= second_len + 1;
            end else begin
              dropped <= 1'b1;
            end
          end
          CMD_ALIGN: begin
            want.best_score = score_overlap();
            want.too_long = dropped;
            awaited_scores.push_back(want);
            first_len <= 0;
            second_len <= 0;
            dropped <= 1'b0;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got.best_score = best_score_i;
        got.too_long = too_long_i;
        if (awaited_scores.size() == 0) begin
          $error("Result with no align pending: best_score %0d too_long %0d",
                 got.best_score, got.too_long);
          errs++;
        end else begin
          want = awaited_scores.pop_front();
          if (got.best_score !== want.best_score) begin
            $error("best_score expected %0d actual %0d", want.best_score, got.best_score);
            errs++;
          end
          if (got.too_long !== want.too_long) begin
            $error("too_long expected %0d actual %0d", want.too_long, got.too_long);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

### test/testbench.sv
// Top of the overlap aligner test: clock, reset, item stimulus, receiver stalls and verdict.
// Depends on sopa_pkg, suffix_prefix_overlap_align and overlap_checker.
`timescale 1ns / 100ps

module testbench;
  import sopa_pkg::*;

  // The slowest run is one full-size alignment plus the small random ones; this
  // limit leaves a wide margin over that.
  localparam int CycleLimit = 1500000;
  localparam int RandomItems = 420;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CMD_W-1:0]  command_i;
  logic [SYM_W-1:0]  symbol_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [RES_W-1:0]  best_score_o;
  logic              too_long_o;
  int                fail_count;
  int                pending;
  int                cycle_count;
  int                burst_left;
  int                items_sent;
  bit                long_hold;

  suffix_prefix_overlap_align dut (.*);

  overlap_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .command_i, .symbol_i,
    .out_valid_i(out_valid_o), .out_stall_i, .best_score_i(best_score_o),
    .too_long_i(too_long_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // The receiver switches between random stall patterns. When the stimulus
  // asks for a long hold-off, it stalls solidly so the queue fills up.
  initial begin
    int mode;
    int span;
    out_stall_i = 1'b1;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = 64;
      end
      span--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (span % 8) < 3;
      endcase
    end
  end

  // Offers one item and waits until the block takes it. Between bursts the valid
  // may drop for a random gap; inside a burst it stays high from item to item.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    symbol_i <= sym;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Lets every outstanding result arrive, then lets trailing appends settle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_weights(input logic [CFG_W-1:0] ms, input logic [CFG_W-1:0] mm,
                             input logic [CFG_W-1:0] gp);
    drain_block();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_MATCH;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_index_i <= REG_MISMATCH;
    cfg_wdata_i <= mm;
    @(posedge clk_i);
    cfg_index_i <= REG_INDEL;
    cfg_wdata_i <= gp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Loads both reads from the given byte lists in a random interleaving, then aligns.
  task automatic run_overlap(input logic [SYM_W-1:0] first_syms [$],
                             input logic [SYM_W-1:0] second_syms [$]);
    while (first_syms.size() + second_syms.size() > 0) begin
      if (second_syms.size() == 0 ||
          (first_syms.size() > 0 && $urandom_range(0, 1) == 0)) begin
        send_item(CMD_APPEND_FIRST, first_syms.pop_front());
      end else begin
        send_item(CMD_APPEND_SECOND, second_syms.pop_front());
      end
      // Occasional unused command mixed in as noise.
      if ($urandom_range(0, 19) == 0) send_item(CMD_NONE, SYM_W'($urandom_range(0, 255)));
    end
    send_item(CMD_ALIGN, SYM_W'($urandom_range(0, 255)));
  endtask

  // Builds a random read pair; the second read often starts with a suffix of the first.
  task automatic random_overlap(input int max_len);
    logic [SYM_W-1:0] a [$];
    logic [SYM_W-1:0] b [$];
    logic [SYM_W-1:0] base;
    int n1;
    int n2;
    int k;
    bit narrow;
    n1 = $urandom_range(0, max_len);
    n2 = $urandom_range(0, max_len);
    base = SYM_W'($urandom_range(0, 255));
    narrow = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < n1; i++) begin
      a.push_back(narrow ? base + SYM_W'($urandom_range(0, 3))
                         : SYM_W'($urandom_range(0, 255)));
    end
    k = (n1 < n2) ? n1 : n2;
    k = $urandom_range(0, k);
    for (int i = 0; i < n2; i++) begin
      if (i < k && $urandom_range(0, 5) != 0) b.push_back(a[n1 - k + i]);
      else b.push_back(narrow ? base + SYM_W'($urandom_range(0, 3))
                              : SYM_W'($urandom_range(0, 255)));
    end
    run_overlap(a, b);
  endtask

  initial begin
    logic [SYM_W-1:0] a [$];
    logic [SYM_W-1:0] b [$];
    int aligns;
    bit held;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_MATCH;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_APPEND_FIRST;
    symbol_i = '0;
    long_hold = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset weights: both reads empty, one read empty, zero and
    // all-ones bytes, an exact suffix-prefix overlap, and the unused command.
    a = {}; b = {};
    run_overlap(a, b);
    a = {8'h00, 8'hff}; b = {};
    run_overlap(a, b);
    a = {}; b = {8'h00};
    run_overlap(a, b);
    a = {8'h41, 8'h43, 8'h00, 8'hff}; b = {8'h00, 8'hff, 8'h41};
    run_overlap(a, b);
    send_item(CMD_NONE, 8'hff);

    // Extreme weights: everything zero, then everything at its top value.
    set_weights('0, '0, '0);
    a = {8'h12, 8'h34}; b = {8'h34, 8'h56};
    run_overlap(a, b);
    set_weights('1, '1, '1);
    a = {8'haa, 8'h55, 8'h00}; b = {8'h55, 8'h00, 8'h01};
    run_overlap(a, b);

    // Both reads one symbol past the limit with identical stored parts, at the top
    // match score: the highest score together with the overflow flag.
    set_weights('1, '0, '0);
    a = {};
    for (int i = 0; i <= MaxLen; i++) a.push_back(SYM_W'($urandom_range(0, 255)));
    b = a;
    run_overlap(a, b);

    // Random part: weight settings change between phases, extremes included.
    items_sent = 0;
    aligns = 0;
    held = 1'b0;
    while (items_sent < RandomItems) begin
      if (aligns % 12 == 0) begin
        case ($urandom_range(0, 3))
          0: set_weights('1, '1, '1);
          1: set_weights(CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(0, 3)),
                         CFG_W'($urandom_range(0, 3)));
          default: set_weights(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                               CFG_W'($urandom_range(0, 15)));
        endcase
      end
      if (!held && items_sent > RandomItems / 2) begin
        // Long receiver hold-off while short aligns keep coming.
        held = 1'b1;
        long_hold = 1'b1;
        for (int i = 0; i < 16; i++) random_overlap(1);
      end
      random_overlap(($urandom_range(0, 9) == 0) ? 24 : 8);
      aligns++;
    end
    drain_block();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/sopa_pkg.sv
sv/sopa_ram.sv
sv/sopa_front.sv
sv/sopa_back.sv
sv/suffix_prefix_overlap_align.sv
test/overlap_checker.sv
test/testbench.sv
